// ===== hdl/ledc_pkg.sv =====
// ----------------------------------------------------------------------------
// ledc_pkg
// Shared types and constants of the addressable LED chain driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ledc_pkg;

   // Size of the colour store
   localparam int LED_COUNT = 16;
   localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   // Field widths
   localparam int OP_W      = 2;
   localparam int INDEX_W   = 10;
   localparam int LEVEL_W   = 8;
   localparam int COLOUR_W  = 3 * LEVEL_W;
   localparam int BIT_W     = 5;
   localparam int TICKS_W   = 8;
   localparam int GAP_W     = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = GAP_W;

   // Last bit position of one LED word
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COLOUR_W - 1);

   // Item operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_GAP = 3'd4;

   // Register reset values
   localparam logic [TICKS_W-1:0] ONE_HIGH_RST  = 8'd3;
   localparam logic [TICKS_W-1:0] ONE_LOW_RST   = 8'd1;
   localparam logic [TICKS_W-1:0] ZERO_HIGH_RST = 8'd1;
   localparam logic [TICKS_W-1:0] ZERO_LOW_RST  = 8'd3;
   localparam logic [GAP_W-1:0]   LATCH_GAP_RST = 18'd80000;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2,
      PH_GAP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] led_index;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
   } req_item_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [TICKS_W-1:0] one_high_ticks;
      logic [TICKS_W-1:0] one_low_ticks;
      logic [TICKS_W-1:0] zero_high_ticks;
      logic [TICKS_W-1:0] zero_low_ticks;
      logic [GAP_W-1:0]   latch_gap_ticks;
   } timing_type;

endpackage

`default_nettype wire

// ===== hdl/ledc_chan_if.sv =====
// ----------------------------------------------------------------------------
// ledc_chan_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ledc_req_if;
   logic                  valid;
   logic                  ready;
   ledc_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface ledc_rsp_if;
   logic                  valid;
   logic                  ready;
   ledc_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/ledc_csr.sv =====
// ----------------------------------------------------------------------------
// ledc_csr
// Timing registers of the LED chain driver, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module ledc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [ledc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ledc_pkg::CSR_DAT_W-1:0] csr_data,
   output ledc_pkg::timing_type                timing
);

   ledc_pkg::timing_type timing_ff;
   ledc_pkg::timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write_en) begin
         case (csr_index)
            ledc_pkg::CSR_ONE_HIGH:
               timing_in.one_high_ticks  = csr_data[ledc_pkg::TICKS_W-1:0];
            ledc_pkg::CSR_ONE_LOW:
               timing_in.one_low_ticks   = csr_data[ledc_pkg::TICKS_W-1:0];
            ledc_pkg::CSR_ZERO_HIGH:
               timing_in.zero_high_ticks = csr_data[ledc_pkg::TICKS_W-1:0];
            ledc_pkg::CSR_ZERO_LOW:
               timing_in.zero_low_ticks  = csr_data[ledc_pkg::TICKS_W-1:0];
            ledc_pkg::CSR_LATCH_GAP:
               timing_in.latch_gap_ticks = csr_data[ledc_pkg::GAP_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.one_high_ticks  <= ledc_pkg::ONE_HIGH_RST;
         timing_ff.one_low_ticks   <= ledc_pkg::ONE_LOW_RST;
         timing_ff.zero_high_ticks <= ledc_pkg::ZERO_HIGH_RST;
         timing_ff.zero_low_ticks  <= ledc_pkg::ZERO_LOW_RST;
         timing_ff.latch_gap_ticks <= ledc_pkg::LATCH_GAP_RST;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

`default_nettype wire

// ===== hdl/ledc_engine.sv =====
// ----------------------------------------------------------------------------
// ledc_engine
// Colour store and frame sequencer: applies one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ledc_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  ledc_pkg::req_item_type      item,
   input  ledc_pkg::timing_type        timing,
   output ledc_pkg::rsp_item_type      result
);

   localparam logic [ledc_pkg::LED_IDX_W-1:0] LED_LAST =
      ledc_pkg::LED_IDX_W'(ledc_pkg::LED_COUNT - 1);
   localparam logic [ledc_pkg::GAP_W-1:0] ONE_TICK = ledc_pkg::GAP_W'(1);

   logic [ledc_pkg::COLOUR_W-1:0]  colour_store_ff [ledc_pkg::LED_COUNT];
   logic [ledc_pkg::LED_IDX_W-1:0] current_led_ff, current_led_in;
   logic [ledc_pkg::BIT_W-1:0]     current_bit_ff, current_bit_in;
   ledc_pkg::phase_type            phase_ff, phase_in;
   logic [ledc_pkg::GAP_W-1:0]     tick_count_ff, tick_count_in;

   logic                           store_we;
   logic [ledc_pkg::LED_IDX_W-1:0] store_addr;
   logic [ledc_pkg::COLOUR_W-1:0]  store_data;

   logic [ledc_pkg::COLOUR_W-1:0]  entry;
   logic                           bit_one;
   logic [ledc_pkg::GAP_W-1:0]     dur_raw;
   logic [ledc_pkg::GAP_W-1:0]     dur;
   logic [ledc_pkg::GAP_W-1:0]     count_inc;
   logic                           phase_done;
   logic                           index_ok;
   ledc_pkg::phase_type            shown_phase;

   // Current bit and the length of the phase it is in
   always_comb begin
      entry   = colour_store_ff[current_led_ff];
      bit_one = entry[ledc_pkg::BIT_LAST - current_bit_ff];
      case (phase_ff)
         ledc_pkg::PH_HIGH:
            dur_raw = ledc_pkg::GAP_W'(bit_one ? timing.one_high_ticks
                                               : timing.zero_high_ticks);
         ledc_pkg::PH_LOW:
            dur_raw = ledc_pkg::GAP_W'(bit_one ? timing.one_low_ticks
                                               : timing.zero_low_ticks);
         default:
            dur_raw = timing.latch_gap_ticks;
      endcase
      dur        = (dur_raw == '0) ? ONE_TICK : dur_raw;
      count_inc  = tick_count_ff + ONE_TICK;
      phase_done = !((count_inc < dur) && (count_inc != '0));
      index_ok   = (11'(item.led_index) < 11'(ledc_pkg::LED_COUNT));
   end

   // Next state
   always_comb begin
      current_led_in = current_led_ff;
      current_bit_in = current_bit_ff;
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      store_we       = 1'b0;
      store_addr     = item.led_index[ledc_pkg::LED_IDX_W-1:0];
      store_data     = {item.green_level, item.red_level, item.blue_level};
      if (item_valid) begin
         case (item.op)
            ledc_pkg::OP_WRITE: begin
               store_we = (phase_ff == ledc_pkg::PH_IDLE) && index_ok;
            end
            ledc_pkg::OP_START: begin
               if (phase_ff == ledc_pkg::PH_IDLE) begin
                  current_led_in = '0;
                  current_bit_in = '0;
                  tick_count_in  = '0;
                  phase_in       = ledc_pkg::PH_HIGH;
               end
            end
            ledc_pkg::OP_TICK: begin
               if (phase_ff != ledc_pkg::PH_IDLE) begin
                  tick_count_in = phase_done ? '0 : count_inc;
                  if (phase_done) begin
                     case (phase_ff)
                        ledc_pkg::PH_HIGH: begin
                           phase_in = ledc_pkg::PH_LOW;
                        end
                        ledc_pkg::PH_LOW: begin
                           if (current_bit_ff == ledc_pkg::BIT_LAST) begin
                              current_bit_in = '0;
                              if (current_led_ff == LED_LAST) begin
                                 phase_in = ledc_pkg::PH_GAP;
                              end else begin
                                 current_led_in = current_led_ff + 1'b1;
                                 phase_in       = ledc_pkg::PH_HIGH;
                              end
                           end else begin
                              current_bit_in = current_bit_ff + 1'b1;
                              phase_in       = ledc_pkg::PH_HIGH;
                           end
                        end
                        default: begin
                           phase_in = ledc_pkg::PH_IDLE;
                        end
                     endcase
                  end
               end
            end
            default: begin
               // unused code changes nothing
            end
         endcase
      end
   end

   // Outputs: a tick shows the level it drives, other items the state after
   always_comb begin
      shown_phase       = (item.op == ledc_pkg::OP_TICK) ? phase_ff : phase_in;
      result.line_level = (shown_phase == ledc_pkg::PH_HIGH);
      result.busy_res   = (shown_phase != ledc_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_led_ff <= '0;
         current_bit_ff <= '0;
         phase_ff       <= ledc_pkg::PH_IDLE;
         tick_count_ff  <= '0;
      end else begin
         current_led_ff <= current_led_in;
         current_bit_ff <= current_bit_in;
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ledc_pkg::LED_COUNT; i++) begin
            colour_store_ff[i] <= '0;
         end
      end else if (store_we) begin
         colour_store_ff[store_addr] <= store_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/addressable_led_chain_driver_top.sv =====
// ----------------------------------------------------------------------------
// addressable_led_chain_driver_top
// Single-wire LED chain driver with a 16-entry colour store.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per handshake: write a colour entry, start a
//   frame, or one clock tick of the output waveform. rsp_chan returns exactly
//   one item per request item, in order: the data pin level and busy flag.
//   The user writes timing registers on the csr_ port only with no item in
//   flight (unchecked); a change during a frame applies from the next tick.
// Data path and throughput:
//   An accepted item is held in the input register, is applied to the
//   sequencer state as it moves to the result register, and is then offered
//   on rsp_chan from the result register. One item is taken every cycle while
//   rsp_chan is ready; the state update of a single item sets that figure.
// Stalls:
//   When rsp_chan is not ready the result register holds its item and the
//   input register fills; req_chan.ready then drops until the result is taken.
// Reset:
//   Synchronous reset empties both registers, clears the colour store to
//   black, puts the sequencer in idle and loads the default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module addressable_led_chain_driver_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ledc_req_if.sink                            req_chan,
   ledc_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_en,
   input  wire logic [ledc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ledc_pkg::CSR_DAT_W-1:0] csr_data
);

   // Input register
   logic                   in_valid_ff, in_valid_in;
   ledc_pkg::req_item_type in_item_ff;

   // Result register
   logic                   out_valid_ff, out_valid_in;
   ledc_pkg::rsp_item_type out_item_ff;

   ledc_pkg::timing_type   timing;
   ledc_pkg::rsp_item_type result;
   logic                   advance;
   logic                   req_take;

   // Advance the input item when the result register is free or being emptied
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   ledc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .timing       (timing)
   );

   ledc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .timing     (timing),
      .result     (result)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

endmodule

`default_nettype wire

// ===== hdl/ledc_checker.sv =====
// ----------------------------------------------------------------------------
// ledc_checker
// Port-level checks on the LED chain driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ledc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic line_level,
   input wire logic busy_res
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result offered after reset");

   // A high pin only ever appears inside a frame
   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!line_level || busy_res))
      else $error("line high while idle");

   // A free receiver never stalls the sender
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled with receiver ready");

   // An accepted item reaches the result side when the receiver stays ready
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after accepted item");

endmodule

bind addressable_led_chain_driver_top ledc_checker u_ledc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .line_level (rsp_chan.item.line_level),
   .busy_res   (rsp_chan.item.busy_res)
);

`default_nettype wire
